### sv/slm_pkg.sv
// Package for the scheduler latency monitor: sequencer states, event and
// request codes, register indexes and reciprocal constants. No dependencies.
`default_nettype none
package slm_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OLD,
        ST_RD,
        ST_CHK,
        ST_BINRD,
        ST_BINWR,
        ST_MUL,
        ST_HRD,
        ST_HOUT
    } t_state;

    localparam logic [2:0] FUNC_WAKEUP = 3'd0;
    localparam logic [2:0] FUNC_SWITCH = 3'd1;
    localparam logic [2:0] FUNC_HANG   = 3'd2;
    localparam logic [2:0] FUNC_EXIT   = 3'd3;
    localparam logic [2:0] FUNC_HREAD  = 3'd4;

    localparam logic [1:0] KIND_OFFCPU = 2'd0;
    localparam logic [1:0] KIND_HANG   = 2'd1;
    localparam logic [1:0] KIND_EXIT   = 2'd2;
    localparam logic [1:0] KIND_HIST   = 2'd3;

    localparam logic [2:0] REG_SCOPE_MODE  = 3'd0;
    localparam logic [2:0] REG_SCOPE_VALUE = 3'd1;
    localparam logic [2:0] REG_OFF_MIN     = 3'd2;
    localparam logic [2:0] REG_OFF_MAX     = 3'd3;
    localparam logic [2:0] REG_TASK_KIND   = 3'd4;

    localparam logic [2:0] SCOPE_ALL    = 3'd1;
    localparam logic [2:0] SCOPE_NS     = 3'd2;
    localparam logic [2:0] SCOPE_PROC   = 3'd4;
    localparam logic [2:0] SCOPE_PGROUP = 3'd5;
    localparam logic [2:0] SCOPE_NONE_A = 3'd6;
    localparam logic [2:0] SCOPE_NONE_B = 3'd7;

    localparam logic [1:0] TKIND_ALL    = 2'd0;
    localparam logic [1:0] TKIND_USER   = 2'd1;
    localparam logic [1:0] TKIND_KERNEL = 2'd2;
    localparam logic [1:0] TKIND_NONE   = 2'd3;

    // nanoseconds per microsecond, base of the bin thresholds
    localparam logic [9:0]  US_NS     = 10'd1000;
    // ceil(2^83 / 1000000): exact quotient by 1000000 for any 63-bit time
    localparam logic [63:0] MS_RECIP  = 64'd9671406556917033398;
    localparam int          MS_SHIFT  = 83;

    localparam logic [62:0] RST_OFF_MIN = 63'd5000000000;
    localparam logic [62:0] RST_OFF_MAX = 63'd50000000000;

endpackage
`default_nettype wire

### sv/sched_latency_monitor.sv
// Scheduler latency monitor top level: start-time memories, histogram memory,
// sequencer and a multi-cycle reciprocal multiplier. Depends on slm_pkg.
`default_nettype none
// After reset the block sweeps both start-time memories and the histogram,
// one entry a cycle, with busy high; configuration writes are taken
// throughout. A request is taken when start is high and busy is low. A hang
// is reported from idle, a wakeup records the run-queue start, an exit clears
// both entries and is reported, and a histogram read reports one bin. A
// switch updates the old task's entries; unless no task is switched in or the
// old task is ending, it then checks the incoming task's entries, bins a
// run-queue wait and reports an off-CPU event where each applies. The bin is
// found by comparing the wait against 1000 ns thresholds doubled per bin; the
// milliseconds come from a reciprocal product built from four 32 by 32
// partial products, one a cycle. Results are held on the o_ ports for exactly
// one cycle, marked by o_valid; the receiver cannot stall them.
module sched_latency_monitor #(
    parameter int MAX_TASKS  = 4096,
    parameter int HIST_SLOTS = 26
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_func,
    input  wire logic [63:0] i_now_ns,
    input  wire logic [11:0] i_task_id,
    input  wire logic [31:0] i_group_id,
    input  wire logic [31:0] i_namespace_id,
    input  wire logic [31:0] i_pgroup_id,
    input  wire logic        i_is_kernel_thread,
    input  wire logic        i_still_runnable,
    input  wire logic        i_is_ending,
    input  wire logic [11:0] i_next_task_id,
    input  wire logic [31:0] i_next_group_id,
    input  wire logic [4:0]  i_hist_slot,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [62:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [1:0]       o_event_kind,
    output logic [11:0]      o_thread_id,
    output logic [31:0]      o_process_id,
    output logic [43:0]      o_offcpu_ms,
    output logic [63:0]      o_bin_count
);

    localparam int AW    = $clog2(MAX_TASKS);
    localparam int SW    = (HIST_SLOTS > 1) ? $clog2(HIST_SLOTS) : 1;
    localparam int SWEEP = (MAX_TASKS > HIST_SLOTS) ? MAX_TASKS : HIST_SLOTS;
    localparam int CW    = $clog2(SWEEP);

    // Configuration registers
    logic [2:0]  r_scope_mode;
    logic [31:0] r_scope_value;
    logic [62:0] r_off_min;
    logic [62:0] r_off_max;
    logic [1:0]  r_task_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scope_mode  <= slm_pkg::SCOPE_ALL;
            r_scope_value <= '0;
            r_off_min     <= slm_pkg::RST_OFF_MIN;
            r_off_max     <= slm_pkg::RST_OFF_MAX;
            r_task_kind   <= slm_pkg::TKIND_ALL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                slm_pkg::REG_SCOPE_MODE:  r_scope_mode  <= i_cfg_wdata[2:0];
                slm_pkg::REG_SCOPE_VALUE: r_scope_value <= i_cfg_wdata[31:0];
                slm_pkg::REG_OFF_MIN:     r_off_min     <= i_cfg_wdata;
                slm_pkg::REG_OFF_MAX:     r_off_max     <= i_cfg_wdata;
                slm_pkg::REG_TASK_KIND:   r_task_kind   <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Latched request
    logic [2:0]  r_func;
    logic [63:0] r_now;
    logic [11:0] r_tid;
    logic [31:0] r_gid;
    logic [31:0] r_nsid;
    logic [31:0] r_pgid;
    logic        r_kthread;
    logic        r_runnable;
    logic        r_ending;
    logic [11:0] r_ntid;
    logic [31:0] r_ngid;
    logic [4:0]  r_hslot;

    // Sequencer and datapath registers
    slm_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_clr;
    logic [1:0]    r_cnt;
    logic [SW-1:0] r_bin;
    logic [63:0]   r_off_d;
    logic          r_off_hit;
    logic [127:0]  r_acc;

    // Memories: valid bit on top of the start time in the two start-time memories
    logic [64:0] runq_mem [MAX_TASKS];
    logic [64:0] offc_mem [MAX_TASKS];
    logic [63:0] bin_mem  [HIST_SLOTS];
    logic [64:0] r_runq_q;
    logic [64:0] r_offc_q;
    logic [63:0] r_bin_q;

    logic        runq_we, offc_we, bin_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [64:0] runq_wdata, offc_wdata;
    logic [SW-1:0] bin_waddr, bin_raddr;
    logic [63:0] bin_wdata;

    always_ff @(posedge i_clk) begin
        if (runq_we) runq_mem[mem_waddr] <= runq_wdata;
        if (offc_we) offc_mem[mem_waddr] <= offc_wdata;
        r_runq_q <= runq_mem[mem_raddr];
        r_offc_q <= offc_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
        r_bin_q <= bin_mem[bin_raddr];
    end

    // Task slots: ids reduced to their low AW bits (modulo the table depth when it is a power of two)
    logic [31:0] tid_ext, ntid_ext, clr_ext;
    logic [AW-1:0] t_idx, n_idx, c_idx;
    assign tid_ext  = 32'(r_tid);
    assign ntid_ext = 32'(r_ntid);
    assign clr_ext  = 32'(r_clr);
    assign t_idx    = tid_ext[AW-1:0];
    assign n_idx    = ntid_ext[AW-1:0];
    assign c_idx    = clr_ext[AW-1:0];

    // Scope and task-kind filters on the latched task
    logic scope_ok, kind_ok;
    always_comb begin
        case (r_scope_mode) inside
            slm_pkg::SCOPE_NS:     scope_ok = (r_nsid == r_scope_value);
            slm_pkg::SCOPE_PROC:   scope_ok = (r_gid == r_scope_value);
            slm_pkg::SCOPE_PGROUP: scope_ok = (r_pgid == r_scope_value);
            slm_pkg::SCOPE_NONE_A,
            slm_pkg::SCOPE_NONE_B: scope_ok = 1'b0;
            default:               scope_ok = 1'b1;
        endcase
        case (r_task_kind)
            slm_pkg::TKIND_ALL:    kind_ok = 1'b1;
            slm_pkg::TKIND_USER:   kind_ok = !r_kthread;
            slm_pkg::TKIND_KERNEL: kind_ok = r_kthread;
            default:               kind_ok = 1'b0;
        endcase
    end

    // Elapsed times against the entries read back
    logic [63:0] rq_d, oc_d;
    logic        rq_bin, oc_hit;
    assign rq_d   = r_now - r_runq_q[63:0];
    assign oc_d   = r_now - r_offc_q[63:0];
    assign rq_bin = r_runq_q[64] && !rq_d[63];
    assign oc_hit = r_offc_q[64] && (oc_d != '0) && !oc_d[63]
                    && (oc_d >= {1'b0, r_off_min}) && (oc_d <= {1'b0, r_off_max});

    // Floor-log2 bin of the wait in microseconds, clamped to the last slot:
    // bin k once the wait reaches 1000 ns shifted left by k
    logic [SW-1:0] lat_bin;
    always_comb begin
        lat_bin = '0;
        for (int k = 1; k < HIST_SLOTS; k++) begin
            if ({10'd0, rq_d} >= (74'(slm_pkg::US_NS) << k)) lat_bin = SW'(k);
        end
    end

    // Reciprocal product for the millisecond quotient, one partial a cycle
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;
    logic [127:0] mul_term, acc_nx;
    always_comb begin
        mul_a = r_cnt[0] ? r_off_d[63:32] : r_off_d[31:0];
        mul_b = r_cnt[1] ? slm_pkg::MS_RECIP[63:32] : slm_pkg::MS_RECIP[31:0];
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
        case (r_cnt)
            2'd0:    mul_term = {64'd0, mul_p};
            2'd3:    mul_term = {mul_p, 64'd0};
            default: mul_term = {32'd0, mul_p, 32'd0};
        endcase
        acc_nx = r_acc + mul_term;
    end

    logic [6:0] hslot_ext;
    logic       hslot_ok;
    assign hslot_ext = {2'b00, r_hslot};
    assign hslot_ok  = (32'(hslot_ext) < HIST_SLOTS);

    logic accept;
    assign accept = start && (r_state == slm_pkg::ST_IDLE);
    assign busy   = (r_state != slm_pkg::ST_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slm_pkg::ST_CLEAR:
                if (r_clr == CW'(SWEEP - 1)) n_state = slm_pkg::ST_IDLE;
            slm_pkg::ST_IDLE:
                if (accept) begin
                    unique case (i_func) inside
                        slm_pkg::FUNC_WAKEUP,
                        slm_pkg::FUNC_SWITCH,
                        slm_pkg::FUNC_EXIT:  n_state = slm_pkg::ST_OLD;
                        slm_pkg::FUNC_HREAD: n_state = slm_pkg::ST_HRD;
                        default:             n_state = slm_pkg::ST_IDLE;
                    endcase
                end
            slm_pkg::ST_OLD:
                if (r_func == slm_pkg::FUNC_SWITCH && !r_ending && r_ntid != '0)
                    n_state = slm_pkg::ST_RD;
                else
                    n_state = slm_pkg::ST_IDLE;
            slm_pkg::ST_RD:  n_state = slm_pkg::ST_CHK;
            slm_pkg::ST_CHK:
                if (rq_bin)      n_state = slm_pkg::ST_BINRD;
                else if (oc_hit) n_state = slm_pkg::ST_MUL;
                else             n_state = slm_pkg::ST_IDLE;
            slm_pkg::ST_BINRD: n_state = slm_pkg::ST_BINWR;
            slm_pkg::ST_BINWR:
                n_state = r_off_hit ? slm_pkg::ST_MUL : slm_pkg::ST_IDLE;
            slm_pkg::ST_MUL:
                if (r_cnt == 2'd3) n_state = slm_pkg::ST_IDLE;
            slm_pkg::ST_HRD:  n_state = slm_pkg::ST_HOUT;
            slm_pkg::ST_HOUT: n_state = slm_pkg::ST_IDLE;
            default:          n_state = slm_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory ports and the result strobe
    logic        n_o_valid;
    logic [1:0]  n_kind;
    logic [11:0] n_thread;
    logic [31:0] n_process;
    logic [43:0] n_ms;
    logic [63:0] n_count;

    always_comb begin
        runq_we    = 1'b0;
        offc_we    = 1'b0;
        bin_we     = 1'b0;
        mem_waddr  = t_idx;
        mem_raddr  = n_idx;
        runq_wdata = {1'b0, r_now};
        offc_wdata = {1'b0, r_now};
        bin_waddr  = r_bin;
        bin_raddr  = r_bin;
        bin_wdata  = r_bin_q + 64'd1;
        n_o_valid  = 1'b0;
        n_kind     = slm_pkg::KIND_OFFCPU;
        n_thread   = '0;
        n_process  = '0;
        n_ms       = '0;
        n_count    = '0;
        unique case (r_state)
            slm_pkg::ST_CLEAR: begin
                mem_waddr = c_idx;
                runq_we   = (clr_ext < MAX_TASKS);
                offc_we   = (clr_ext < MAX_TASKS);
                bin_waddr = clr_ext[SW-1:0];
                bin_we    = (clr_ext < HIST_SLOTS);
                bin_wdata = '0;
            end
            slm_pkg::ST_IDLE:
                if (accept && i_func == slm_pkg::FUNC_HANG) begin
                    n_o_valid = 1'b1;
                    n_kind    = slm_pkg::KIND_HANG;
                    n_thread  = i_task_id;
                    n_process = i_group_id;
                end
            slm_pkg::ST_OLD: begin
                unique case (r_func)
                    slm_pkg::FUNC_WAKEUP: begin
                        runq_we    = scope_ok;
                        runq_wdata = {1'b1, r_now};
                    end
                    slm_pkg::FUNC_SWITCH: begin
                        // ending tasks lose both entries
                        runq_we    = r_ending || (r_runnable && scope_ok);
                        runq_wdata = {!r_ending, r_now};
                        offc_we    = r_ending || (scope_ok && kind_ok);
                        offc_wdata = {!r_ending, r_now};
                    end
                    default: begin
                        runq_we   = 1'b1;
                        offc_we   = 1'b1;
                        n_o_valid = 1'b1;
                        n_kind    = slm_pkg::KIND_EXIT;
                        n_thread  = r_tid;
                        n_process = r_gid;
                    end
                endcase
            end
            slm_pkg::ST_CHK: begin
                // drop both entries of the incoming task once looked at
                mem_waddr = n_idx;
                runq_we   = 1'b1;
                offc_we   = 1'b1;
            end
            slm_pkg::ST_BINWR: bin_we = 1'b1;
            slm_pkg::ST_MUL:
                if (r_cnt == 2'd3) begin
                    n_o_valid = 1'b1;
                    n_kind    = slm_pkg::KIND_OFFCPU;
                    n_thread  = r_ntid;
                    n_process = r_ngid;
                    n_ms      = acc_nx[slm_pkg::MS_SHIFT +: 44];
                end
            slm_pkg::ST_HRD: bin_raddr = hslot_ext[SW-1:0];
            slm_pkg::ST_HOUT: begin
                n_o_valid = 1'b1;
                n_kind    = slm_pkg::KIND_HIST;
                n_count   = hslot_ok ? r_bin_q : '0;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slm_pkg::ST_CLEAR;
            r_clr   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= n_o_valid;
            if (r_state == slm_pkg::ST_CLEAR) r_clr <= r_clr + CW'(1);
        end
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        o_event_kind <= n_kind;
        o_thread_id  <= n_thread;
        o_process_id <= n_process;
        o_offcpu_ms  <= n_ms;
        o_bin_count  <= n_count;

        if (accept) begin
            r_func     <= i_func;
            r_now      <= i_now_ns;
            r_tid      <= i_task_id;
            r_gid      <= i_group_id;
            r_nsid     <= i_namespace_id;
            r_pgid     <= i_pgroup_id;
            r_kthread  <= i_is_kernel_thread;
            r_runnable <= i_still_runnable;
            r_ending   <= i_is_ending;
            r_ntid     <= i_next_task_id;
            r_ngid     <= i_next_group_id;
            r_hslot    <= i_hist_slot;
        end

        // hold the bin and the off-CPU time for the later steps
        if (r_state == slm_pkg::ST_CHK) begin
            r_off_d   <= oc_d;
            r_off_hit <= oc_hit;
            r_bin     <= lat_bin;
        end

        if (r_state == slm_pkg::ST_MUL) begin
            r_cnt <= r_cnt + 2'd1;
            r_acc <= acc_nx;
        end else begin
            r_cnt <= '0;
            r_acc <= '0;
        end
    end

endmodule
`default_nettype wire
